@@ sv/assert_macros.svh @@
// Assertion macros shared by the decimator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Assertion failed: same-cycle implication does not hold.");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Assertion failed: next-cycle implication does not hold.");

`endif

@@ sv/bavg_pkg.sv @@
// Package with the constants and types shared by the decimator modules.
package bavg_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int POINTS_CAP  = 256;
  localparam int SAMPLE_W    = 24;
  localparam int NUM_LANES   = 4;
  localparam int TAG_W       = 32;

  localparam int TC_W      = 11;
  localparam int OP_W      = 9;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int PTS_W  = $clog2(POINTS_CAP + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES) + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int ACC_W  = $clog2((MAX_SAMPLES + 2) * (POINTS_CAP + 1) + 1);

  localparam int RESET_OUT_POINTS = 200;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINTS  = CFG_IDX_W'(1);

  localparam int LANE_TEMPERATURE  = 0;
  localparam int LANE_HUMIDITY     = 1;
  localparam int LANE_GAS          = 2;
  localparam int LANE_ACCELERATION = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic             close;
    logic [CNT_W-1:0] count;
  } lane_ctl_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
    logic             last;
  } point_info_t;

endpackage

@@ sv/bavg_lane.sv @@
// One channel lane: bin accumulator and a bit-serial signed divider for the mean.
`include "assert_macros.svh"

module bavg_lane (
  input  logic                clk,
  input  logic                rst,
  input  bavg_pkg::lane_ctl_t ctl,
  input  bavg_pkg::sample_t   sample,
  output bavg_pkg::sample_t   mean,
  output logic                idle
);
  import bavg_pkg::*;

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] sum_new;
  logic        [SUM_W-1:0] sum_abs;
  logic        [MAG_W-1:0] dvd;
  logic        [MAG_W-1:0] quot_signed;
  logic        [CNT_W-1:0] rem;
  logic        [CNT_W-1:0] divisor;
  logic        [CNT_W:0]   shifted;
  logic        [CNT_W:0]   diff;
  logic                    fits;
  logic                    neg;
  logic                    busy;
  logic        [STEP_W-1:0] step;

  assign sum_new = acc + SUM_W'(sample);
  assign sum_abs = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;

  assign shifted = {rem, dvd[MAG_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  assign quot_signed = neg ? (~dvd + MAG_W'(1)) : dvd;
  assign mean        = sample_t'(quot_signed[SAMPLE_W-1:0]);
  assign idle        = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.clear) begin
      acc  <= '0;
      busy <= 1'b0;
      step <= '0;
    end else begin
      if (ctl.add) begin
        if (ctl.close) begin
          acc     <= '0;
          dvd     <= sum_abs[MAG_W-1:0];
          neg     <= sum_new[SUM_W-1];
          divisor <= ctl.count;
          rem     <= '0;
          busy    <= 1'b1;
          step    <= '0;
        end else begin
          acc <= sum_new;
        end
      end
      if (busy) begin
        rem  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        dvd  <= {dvd[MAG_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `ASSERT_IMPLIES(a_close_while_idle, clk, rst, ctl.add && ctl.close, !busy)
  `ASSERT_IMPLIES(a_divisor_nonzero, clk, rst, ctl.add && ctl.close, ctl.count != '0)

endmodule

@@ sv/bavg_ctrl.sv @@
// Run control: configuration registers, sample and bin counters, bin closing decision.
`include "assert_macros.svh"

module bavg_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bavg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bavg_pkg::TAG_W-1:0]   time_tag,
  input  logic                         lanes_idle,
  input  logic                         room,
  output bavg_pkg::lane_ctl_t          lane_ctl,
  output logic                         load,
  output bavg_pkg::point_info_t        info
);
  import bavg_pkg::*;

  typedef enum logic {ST_ACCUM, ST_DIVIDE} state_t;

  state_t           state;
  logic [TC_W-1:0]  total_count;
  logic [OP_W-1:0]  out_points;
  logic [CNT_W-1:0] sample_index;
  logic [CNT_W-1:0] fill;
  logic [TAG_W-1:0] first_tag;
  logic [ACC_W-1:0] lim_a;
  logic [ACC_W-1:0] lim_b;
  point_info_t      pend;

  logic [TC_W-1:0]  tc_new;
  logic [OP_W-1:0]  op_new;
  logic [CNT_W-1:0] n_eff;
  logic [PTS_W-1:0] m_eff;
  logic [CNT_W-1:0] n_new;
  logic [PTS_W-1:0] m_new;
  logic             cfg_hit;
  logic             in_acc;
  logic             active;
  logic             pass;
  logic             close;
  logic             take;

  function automatic logic [CNT_W-1:0] eff_n(input logic [TC_W-1:0] tc);
    if (int'(tc) > MAX_SAMPLES) return CNT_W'(MAX_SAMPLES);
    return CNT_W'(tc);
  endfunction

  function automatic logic [PTS_W-1:0] eff_m(input logic [OP_W-1:0] op);
    if (op == '0) return PTS_W'(1);
    if (int'(op) > POINTS_CAP) return PTS_W'(POINTS_CAP);
    return PTS_W'(op);
  endfunction

  assign cfg_hit = cfg_we && (cfg_index == REG_TOTAL_COUNT || cfg_index == REG_OUT_POINTS);
  assign tc_new  = (cfg_index == REG_TOTAL_COUNT) ? cfg_data[TC_W-1:0] : total_count;
  assign op_new  = (cfg_index == REG_OUT_POINTS) ? cfg_data[OP_W-1:0] : out_points;
  assign n_new   = eff_n(tc_new);
  assign m_new   = eff_m(op_new);
  assign n_eff   = eff_n(total_count);
  assign m_eff   = eff_m(out_points);

  assign in_stall = (state != ST_ACCUM);
  assign in_acc   = in_valid && (state == ST_ACCUM);
  assign active   = sample_index < n_eff;
  assign pass     = ACC_W'(n_eff) <= ACC_W'(m_eff);
  assign close    = pass || (lim_a < lim_b);
  assign take     = in_acc && active;

  assign lane_ctl.clear = cfg_hit;
  assign lane_ctl.add   = take && !cfg_hit;
  assign lane_ctl.close = close;
  assign lane_ctl.count = fill + CNT_W'(1);

  assign load = (state == ST_DIVIDE) && lanes_idle && room && !cfg_hit;
  assign info = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACCUM;
      total_count  <= '0;
      out_points   <= OP_W'(RESET_OUT_POINTS);
      sample_index <= '0;
      fill         <= '0;
      first_tag    <= '0;
      lim_a        <= '0;
      lim_b        <= ACC_W'(RESET_OUT_POINTS) << 1;
    end else if (cfg_hit) begin
      state        <= ST_ACCUM;
      total_count  <= tc_new;
      out_points   <= op_new;
      sample_index <= '0;
      fill         <= '0;
      first_tag    <= '0;
      lim_a        <= ACC_W'(n_new);
      lim_b        <= ACC_W'(m_new) << 1;
    end else begin
      case (state)
        ST_ACCUM: begin
          if (take) begin
            sample_index <= sample_index + CNT_W'(1);
            lim_b        <= lim_b + ACC_W'(m_eff);
            if (fill == '0) begin
              first_tag <= time_tag;
            end
            if (close) begin
              lim_a      <= lim_a + ACC_W'(n_eff);
              fill       <= '0;
              pend.tag   <= (fill == '0) ? time_tag : first_tag;
              pend.count <= fill + CNT_W'(1);
              pend.last  <= (sample_index + CNT_W'(1)) == n_eff;
              state      <= ST_DIVIDE;
            end else begin
              fill <= fill + CNT_W'(1);
            end
          end
        end
        ST_DIVIDE: begin
          if (load) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_fill_within_index, clk, rst, 1'b1, fill <= sample_index)
  `ASSERT_NEXT(a_close_starts_divide, clk, rst, take && close && !cfg_hit, state == ST_DIVIDE)

endmodule

@@ sv/bavg_merge.sv @@
// Merging stage: gathers the lane means and bin details into the output register.
module bavg_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  bavg_pkg::point_info_t         info,
  input  bavg_pkg::sample_t             means [bavg_pkg::NUM_LANES],
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bavg_pkg::TAG_W-1:0]    point_tag,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_temperature,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_humidity,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_gas,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_acceleration,
  output logic [bavg_pkg::CNT_W-1:0]    bin_samples,
  output logic                          last_point
);
  import bavg_pkg::*;

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point_tag         <= info.tag;
      mean_temperature  <= means[LANE_TEMPERATURE];
      mean_humidity     <= means[LANE_HUMIDITY];
      mean_gas          <= means[LANE_GAS];
      mean_acceleration <= means[LANE_ACCELERATION];
      bin_samples       <= info.count;
      last_point        <= info.last;
    end
  end

endmodule

@@ sv/bin_average_decimator.sv @@
// Top level of the block-average decimator.
//
// Samples arrive on the input channel (in_valid, in_stall) with a time tag
// and four signed channels; averaged points leave on the output channel
// (out_valid, out_stall). The plain write port (cfg_we, cfg_index, cfg_data)
// sets total_count and out_points, and any write to either restarts the run.
// A sample that does not close a bin is taken without stalling the input, so
// such samples stream at one per cycle. A sample that closes a bin starts the
// four lane dividers, which resolve one quotient bit per cycle; the point is
// loaded into the output register once all lanes are idle and the register has
// room, and the input is stalled until the point has moved into that register.
// Samples beyond total_count are taken and dropped.
// Reset clears the run with total_count 0 and out_points 200.
// A point held by a stalled receiver stays in the output register while the
// next bin keeps filling; a further closing bin then waits in the lanes with
// the input stalled until the register frees.
module bin_average_decimator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bavg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bavg_pkg::TAG_W-1:0]           time_tag,
  input  logic signed [bavg_pkg::SAMPLE_W-1:0] temperature,
  input  logic signed [bavg_pkg::SAMPLE_W-1:0] humidity,
  input  logic signed [bavg_pkg::SAMPLE_W-1:0] gas_level,
  input  logic signed [bavg_pkg::SAMPLE_W-1:0] acceleration,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bavg_pkg::TAG_W-1:0]           point_tag,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_temperature,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_humidity,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_gas,
  output logic signed [bavg_pkg::SAMPLE_W-1:0] mean_acceleration,
  output logic [bavg_pkg::CNT_W-1:0]           bin_samples,
  output logic                                 last_point
);
  import bavg_pkg::*;

  lane_ctl_t        lane_ctl;
  point_info_t      info;
  sample_t          samples [NUM_LANES];
  sample_t          means   [NUM_LANES];
  logic [NUM_LANES-1:0] lane_idle;
  logic             lanes_idle;
  logic             load;
  logic             room;

  assign samples[LANE_TEMPERATURE]  = temperature;
  assign samples[LANE_HUMIDITY]     = humidity;
  assign samples[LANE_GAS]          = gas_level;
  assign samples[LANE_ACCELERATION] = acceleration;

  assign lanes_idle = &lane_idle;

  bavg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .time_tag   (time_tag),
    .lanes_idle (lanes_idle),
    .room       (room),
    .lane_ctl   (lane_ctl),
    .load       (load),
    .info       (info)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bavg_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .sample (samples[i]),
      .mean   (means[i]),
      .idle   (lane_idle[i])
    );
  end

  bavg_merge u_merge (
    .clk               (clk),
    .rst               (rst),
    .load              (load),
    .info              (info),
    .means             (means),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .point_tag         (point_tag),
    .mean_temperature  (mean_temperature),
    .mean_humidity     (mean_humidity),
    .mean_gas          (mean_gas),
    .mean_acceleration (mean_acceleration),
    .bin_samples       (bin_samples),
    .last_point        (last_point)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the block-average decimator, with its own bin and mean predictor.
`timescale 1ns / 100ps

module tb_top;
  import bavg_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 6;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_SAMPLES   = 250;
  localparam int RUN_LIMIT_NS     = 10_000_000;
  localparam int REPORT_LIMIT     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum {FILL_MIXED, FILL_PEAK} fill_mode_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    sample_t [NUM_LANES-1:0]   ch;
  } reading_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    sample_t [NUM_LANES-1:0]   mean;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } point_t;

  class bin_mean_board;
    int unsigned      total_count;
    int unsigned      out_points;
    int               sample_index;
    int               bin_index;
    int               next_boundary;
    int               bin_fill;
    longint           lane_sums[NUM_LANES];
    logic [TAG_W-1:0] first_tag;
    point_t           expected_points[$];
    int               mismatches;
    int               points_checked;
    int               samples_taken;
    int               samples_ignored;

    function new();
      total_count = 0;
      out_points  = RESET_OUT_POINTS;
      restart_run();
    endfunction

    function int run_samples();
      return (total_count > MAX_SAMPLES) ? MAX_SAMPLES : total_count;
    endfunction

    function int run_points();
      if (out_points == 0) return 1;
      return (out_points > POINTS_CAP) ? POINTS_CAP : out_points;
    endfunction

    function int samples_left();
      return run_samples() - sample_index;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void clear_bin();
      bin_fill = 0;
      foreach (lane_sums[c]) lane_sums[c] = 0;
    endfunction

    function void restart_run();
      int n;
      int m;
      n = run_samples();
      m = run_points();
      sample_index  = 0;
      bin_index     = 0;
      first_tag     = '0;
      clear_bin();
      next_boundary = (n > m) ? n / m : 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_TOTAL_COUNT) begin
        total_count = data[TC_W-1:0];
      end else if (idx == REG_OUT_POINTS) begin
        out_points = data[OP_W-1:0];
      end else begin
        return;
      end
      restart_run();
    endfunction

    function void note_sample(reading_t r);
      int     n;
      int     m;
      bit     closes;
      point_t p;
      n = run_samples();
      m = run_points();
      if (sample_index >= n) begin
        samples_ignored++;
        return;
      end
      samples_taken++;
      if (bin_fill == 0) first_tag = r.tag;
      for (int c = 0; c < NUM_LANES; c++) lane_sums[c] += longint'(r.ch[c]);
      bin_fill++;
      sample_index++;
      closes = (n <= m) || (sample_index >= next_boundary);
      if (!closes) return;
      p.tag = first_tag;
      for (int c = 0; c < NUM_LANES; c++) p.mean[c] = sample_t'(lane_sums[c] / longint'(bin_fill));
      p.count = CNT_W'(bin_fill);
      p.last  = (sample_index == n);
      expected_points.push_back(p);
      bin_index++;
      if (n > m && bin_index < m) next_boundary = ((bin_index + 1) * n) / m;
      clear_bin();
    endfunction

    function void field_check(string field, longint want, longint got);
      if (want == got) return;
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Point with tag %0d arrived with nothing expected", got.tag);
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      field_check("point_tag", want.tag, got.tag);
      for (int c = 0; c < NUM_LANES; c++)
        field_check($sformatf("mean of lane %0d", c), want.mean[c], got.mean[c]);
      field_check("bin_samples", want.count, got.count);
      field_check("last_point", want.last, got.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [TAG_W-1:0]      time_tag;
  sample_t               temperature;
  sample_t               humidity;
  sample_t               gas_level;
  sample_t               acceleration;
  logic                  out_valid;
  logic                  out_stall;
  logic [TAG_W-1:0]      point_tag;
  sample_t               mean_temperature;
  sample_t               mean_humidity;
  sample_t               mean_gas;
  sample_t               mean_acceleration;
  logic [CNT_W-1:0]      bin_samples;
  logic                  last_point;

  bin_mean_board board;
  bit            tx_steady;
  bit            rx_steady;
  int            hold_requests;
  int            reg_writes;

  bin_average_decimator u_dut (.*);

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic int idle_span(bit steady);
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic reading_t reading_of(logic [TAG_W-1:0] tag, sample_t t, sample_t h,
                                          sample_t g, sample_t a);
    reading_t r;
    r.tag                       = tag;
    r.ch[LANE_TEMPERATURE]      = t;
    r.ch[LANE_HUMIDITY]         = h;
    r.ch[LANE_GAS]              = g;
    r.ch[LANE_ACCELERATION]     = a;
    return r;
  endfunction

  function automatic reading_t random_reading(fill_mode_t mode);
    reading_t r;
    int       pick;
    r.tag = $urandom;
    for (int c = 0; c < NUM_LANES; c++) begin
      pick = $urandom_range(0, 9);
      if (mode == FILL_PEAK) begin
        r.ch[c] = (c % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
      end else if (pick < 5) begin
        r.ch[c] = sample_t'($urandom);
      end else if (pick < 8) begin
        r.ch[c] = sample_t'(int'($urandom_range(0, 16)) - 8);
      end else begin
        case ($urandom_range(0, 3))
          0: r.ch[c] = SAMPLE_MAX;
          1: r.ch[c] = SAMPLE_MIN;
          2: r.ch[c] = '0;
          default: r.ch[c] = '1;
        endcase
      end
    end
    return r;
  endfunction

  task automatic configure(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic send_sample(input reading_t r);
    int gap;
    gap = idle_span(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    time_tag     <= r.tag;
    temperature  <= r.ch[LANE_TEMPERATURE];
    humidity     <= r.ch[LANE_HUMIDITY];
    gas_level    <= r.ch[LANE_GAS];
    acceleration <= r.ch[LANE_ACCELERATION];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(r);
  endtask

  task automatic send_burst(input int count, input fill_mode_t mode);
    repeat (count) send_sample(random_reading(mode));
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : collect
    point_t got;
    if (!rst && out_valid && !out_stall) begin
      got.tag                     = point_tag;
      got.mean[LANE_TEMPERATURE]  = mean_temperature;
      got.mean[LANE_HUMIDITY]     = mean_humidity;
      got.mean[LANE_GAS]          = mean_gas;
      got.mean[LANE_ACCELERATION] = mean_acceleration;
      got.count                   = bin_samples;
      got.last                    = last_point;
      board.check_point(got);
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_stall   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_served < hold_requests) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_served++;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_left = idle_span(rx_steady);
      end
      out_stall <= (hold_left > 0);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int               phase_count;
    int               small_taken;
    int               taken_before;
    int               to_send;
    int               n_left;
    int               pick;
    fill_mode_t       mode;
    logic [CFG_W-1:0] tc_word;
    logic [CFG_W-1:0] op_word;
    board        = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    time_tag     = '0;
    temperature  = '0;
    humidity     = '0;
    gas_level    = '0;
    acceleration = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An empty run after reset ignores everything.
    send_sample(reading_of('1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    send_sample(reading_of('0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
    in_valid <= 1'b0;
    wait_idle();

    // Pass-through with the reset value of out_points, then one sample past the run.
    configure(REG_TOTAL_COUNT, CFG_W'(5));
    cfg_we <= 1'b0;
    send_sample(reading_of('0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
    send_sample(reading_of('1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
    send_sample(reading_of(32'hAAAA_AAAA, 24'h555555, 24'hAAAAAA, '0, '1));
    send_sample(reading_of(32'h5555_5555, 24'hAAAAAA, 24'h555555, '1, '0));
    send_sample(reading_of(32'd1, 24'sd1, -24'sd1, 24'sd2, -24'sd2));
    send_sample(reading_of(32'd2, 24'sd3, 24'sd3, 24'sd3, 24'sd3));
    in_valid <= 1'b0;
    wait_idle();

    // out_points of zero acts as one: a single bin, with negative sums truncated toward zero.
    configure(REG_OUT_POINTS, '0);
    configure(REG_TOTAL_COUNT, CFG_W'(4));
    cfg_we <= 1'b0;
    repeat (3) send_sample(reading_of($urandom, '1, '1, SAMPLE_MAX, SAMPLE_MIN));
    send_sample(reading_of($urandom, '0, -24'sd2, SAMPLE_MAX, SAMPLE_MIN));
    in_valid <= 1'b0;
    wait_idle();

    // Uneven bins; a write to an unused index in mid-run must not restart it.
    configure(REG_TOTAL_COUNT, CFG_W'(7));
    configure(REG_OUT_POINTS, CFG_W'(3));
    cfg_we <= 1'b0;
    send_burst(3, FILL_MIXED);
    wait_idle();
    configure(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
    send_burst(5, FILL_MIXED);

    small_taken = 0;
    phase_count = 0;
    while (small_taken < RANDOM_SAMPLES || phase_count <= 4) begin
      wait_idle();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (phase_count == 1) begin
        // Saturated out_points; the receiver holds off long while samples keep coming.
        configure(REG_TOTAL_COUNT, CFG_W'(300));
        configure(REG_OUT_POINTS, CFG_W'(511));
        cfg_we <= 1'b0;
        tx_steady = 1'b1;
        hold_requests++;
        send_burst(60, FILL_MIXED);
      end else if (phase_count == 4) begin
        // Saturated total_count, out_points masked to four: a first bin of 256 peak samples.
        configure(REG_OUT_POINTS, CFG_W'(516));
        configure(REG_TOTAL_COUNT, CFG_W'(2047));
        cfg_we <= 1'b0;
        send_burst(MAX_SAMPLES / 4, FILL_PEAK);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 1) tc_word = '0;
        else if (pick < 2) tc_word = CFG_W'($urandom_range(1025, 2047));
        else if (pick < 3) tc_word = CFG_W'($urandom_range(49, 160));
        else tc_word = CFG_W'($urandom_range(1, 48));
        pick = $urandom_range(0, 9);
        if (pick < 1) op_word = '0;
        else if (pick < 2) op_word = CFG_W'($urandom_range(256, 511));
        else if (pick < 4) op_word = CFG_W'($urandom_range(1, 255));
        else op_word = CFG_W'($urandom_range(1, 24));
        op_word[CFG_W-1:OP_W] = (CFG_W - OP_W)'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
          configure($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
        case ($urandom_range(0, 3))
          0: configure(REG_TOTAL_COUNT, tc_word);
          1: configure(REG_OUT_POINTS, op_word);
          2: begin
            configure(REG_TOTAL_COUNT, tc_word);
            configure(REG_OUT_POINTS, op_word);
          end
          default: begin
            configure(REG_OUT_POINTS, op_word);
            configure(REG_TOTAL_COUNT, tc_word);
          end
        endcase
        cfg_we <= 1'b0;
        n_left = board.samples_left();
        if (n_left > 160) to_send = $urandom_range(1, 60);
        else if ($urandom_range(0, 3) == 0) to_send = $urandom_range(0, n_left);
        else to_send = n_left + $urandom_range(0, 3);
        mode = ($urandom_range(0, 9) == 0) ? FILL_PEAK : FILL_MIXED;
        taken_before = board.samples_taken;
        send_burst(to_send, mode);
        small_taken += board.samples_taken - taken_before;
      end
      phase_count++;
    end

    wait_idle();
    $display("Run covered %0d samples averaged and %0d dropped past a run's end, %0d points checked,",
             board.samples_taken, board.samples_ignored, board.points_checked);
    $display("over %0d register writes spanning empty, pass-through, binned and saturated runs.",
             reg_writes);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
